// ===== src/rc_differential_drive_mixer_core_macros.svh =====
// Assertion macros shared by the mixer modules.
`ifndef RC_DIFFERENTIAL_DRIVE_MIXER_CORE_MACROS_SVH
`define RC_DIFFERENTIAL_DRIVE_MIXER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define RCDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define RCDD_ASSERT_NEXT(lbl, cond, result, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) else $error(msg);

`else

`define RCDD_ASSERT(lbl, prop, msg)

`define RCDD_ASSERT_NEXT(lbl, cond, result, msg)

`endif

`endif

// ===== src/rcdd_pkg.sv =====
// Shared types, constants and arithmetic helpers of the drive mixer.
package rcdd_pkg;

  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND_US = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_FRAMES = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CMD     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_MASK = 8'd3;

  localparam logic [8:0] DEADBAND_RESET = 9'd80;
  localparam logic [7:0] LOCK_FRAMES_RESET = 8'd10;
  localparam logic [7:0] MIN_CMD_RESET = 8'd10;
  localparam logic [3:0] INVERT_MASK_RESET = 4'd0;

  localparam logic [15:0] PULSE_MIN = 16'd900;
  localparam logic [15:0] PULSE_MAX = 16'd2100;
  localparam logic signed [16:0] PULSE_MID = 17'sd1500;
  localparam logic signed [16:0] SPAN_WIDE = 17'sd500;
  localparam logic signed [10:0] SPAN_SUM = 11'sd500;
  localparam logic signed [9:0] SPAN_OFS = 10'sd500;
  localparam logic [8:0] SPAN_MAG = 9'd500;

  // floor(y / 125) == (y * RECIP_125) >> RECIP_SHIFT for y below 59074
  localparam logic [15:0] RECIP_125 = 16'd33555;
  localparam int RECIP_SHIFT = 22;

  localparam logic [1:0] MODE_BRAKE = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_REV   = 2'd2;

  typedef struct packed {
    logic [8:0] deadband_us;
    logic [7:0] lock_frames;
    logic [7:0] min_cmd;
    logic [3:0] invert_mask;
  } cfg_t;

  typedef struct packed {
    logic [15:0] fwd_us;
    logic [15:0] turn_us;
    logic        drive;
    logic        ok;
  } frame_t;

  typedef struct packed {
    logic       l_neg;
    logic [8:0] l_mag;
    logic       r_neg;
    logic [8:0] r_mag;
    logic       locked;
    logic       ok;
  } mix_t;

  function automatic logic signed [9:0] channel_offset(input logic [15:0] us,
                                                       input logic [8:0] db);
    logic signed [16:0] d;
    logic [16:0] mag;
    d = signed'({1'b0, us}) - PULSE_MID;
    mag = d[16] ? 17'(-d) : 17'(d);
    if (mag <= {8'd0, db}) begin
      channel_offset = 10'sd0;
    end else if (d > SPAN_WIDE) begin
      channel_offset = SPAN_OFS;
    end else if (d < -SPAN_WIDE) begin
      channel_offset = -SPAN_OFS;
    end else begin
      channel_offset = d[9:0];
    end
  endfunction

  function automatic logic [8:0] side_mag(input logic signed [10:0] v);
    if (v > SPAN_SUM || v < -SPAN_SUM) begin
      side_mag = SPAN_MAG;
    end else if (v[10]) begin
      side_mag = 9'(-v);
    end else begin
      side_mag = 9'(v);
    end
  endfunction

  function automatic logic [7:0] scale_duty(input logic [8:0] mag);
    logic [16:0] x;
    logic [30:0] p;
    x = {mag, 8'd0} - {8'd0, mag};
    p = 31'(x[16:2]) * 31'(RECIP_125);
    scale_duty = p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  function automatic logic [1:0] motor_mode(input logic neg, input logic [7:0] duty,
                                           input logic inv);
    if (duty == 8'd0) begin
      motor_mode = MODE_BRAKE;
    end else if (neg == inv) begin
      motor_mode = MODE_FWD;
    end else begin
      motor_mode = MODE_REV;
    end
  endfunction

endpackage

// ===== src/rcdd_lock.sv =====
// Input stage: frame check, lock counter and input register.
`include "rc_differential_drive_mixer_core_macros.svh"

module rcdd_lock (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        fwd_pulse_us,
  input  logic [15:0]        turn_pulse_us,
  input  logic [7:0]         lock_frames,
  output logic               frame_valid,
  output rcdd_pkg::frame_t   frame,
  input  logic               frame_ready
);
  import rcdd_pkg::*;

  logic [7:0] good_frames;
  logic       lock_held;
  logic       ok;
  logic       count_en;
  logic       take;

  assign ok = fwd_pulse_us >= PULSE_MIN && fwd_pulse_us <= PULSE_MAX &&
              turn_pulse_us >= PULSE_MIN && turn_pulse_us <= PULSE_MAX;
  assign count_en = ok && !lock_held && good_frames < lock_frames;
  assign in_ready = !frame_valid || frame_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      good_frames <= 8'd0;
      lock_held <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (take) begin
        if (!ok) begin
          good_frames <= 8'd0;
          lock_held <= 1'b0;
        end else if (count_en) begin
          good_frames <= good_frames + 8'd1;
        end else begin
          lock_held <= 1'b1;
        end
      end
      if (in_ready) begin
        frame_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame.fwd_us <= fwd_pulse_us;
      frame.turn_us <= turn_pulse_us;
      frame.drive <= ok && !count_en;
      frame.ok <= ok;
    end
  end

  `RCDD_ASSERT_NEXT(a_bad_frame_unlocks, take && !ok, !lock_held && good_frames == 8'd0,
                    "bad frame did not clear lock state")
  `RCDD_ASSERT(a_drive_needs_ok, frame_valid && frame.drive |-> frame.ok,
               "drive set on bad frame")

endmodule

// ===== src/rcdd_mix.sv =====
// Mix stage: channel offsets, deadband, arcade sum and difference.
`include "rc_differential_drive_mixer_core_macros.svh"

module rcdd_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  input  rcdd_pkg::frame_t   frame,
  output logic               frame_ready,
  input  logic [8:0]         deadband_us,
  output logic               mix_valid,
  output rcdd_pkg::mix_t     mix,
  input  logic               mix_ready
);
  import rcdd_pkg::*;

  logic signed [9:0]  f_ofs;
  logic signed [9:0]  t_ofs;
  logic signed [10:0] sum;
  logic signed [10:0] diff;
  mix_t               mix_next;

  assign frame_ready = !mix_valid || mix_ready;

  always_comb begin
    f_ofs = channel_offset(frame.fwd_us, deadband_us);
    t_ofs = channel_offset(frame.turn_us, deadband_us);
    sum = {f_ofs[9], f_ofs} + {t_ofs[9], t_ofs};
    diff = {f_ofs[9], f_ofs} - {t_ofs[9], t_ofs};
    mix_next.locked = frame.drive;
    mix_next.ok = frame.ok;
    if (frame.drive) begin
      mix_next.l_neg = sum[10];
      mix_next.l_mag = side_mag(sum);
      mix_next.r_neg = diff[10];
      mix_next.r_mag = side_mag(diff);
    end else begin
      mix_next.l_neg = 1'b0;
      mix_next.l_mag = 9'd0;
      mix_next.r_neg = 1'b0;
      mix_next.r_mag = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (frame_ready) begin
      mix_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      mix <= mix_next;
    end
  end

  `RCDD_ASSERT(a_mag_in_span, mix_valid |-> mix.l_mag <= SPAN_MAG && mix.r_mag <= SPAN_MAG,
               "side magnitude beyond span")
  `RCDD_ASSERT(a_idle_zero, mix_valid && !mix.locked |-> mix.l_mag == 9'd0 && mix.r_mag == 9'd0,
               "nonzero side while not driving")

endmodule

// ===== src/rcdd_scale.sv =====
// Output stage: duty scaling, minimum command and motor mode decode.
`include "rc_differential_drive_mixer_core_macros.svh"

module rcdd_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               mix_valid,
  input  rcdd_pkg::mix_t     mix,
  output logic               mix_ready,
  input  logic [7:0]         min_cmd,
  input  logic [3:0]         invert_mask,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [8:0]  left_cmd,
  output logic signed [8:0]  right_cmd,
  output logic [1:0]         fl_mode,
  output logic [7:0]         fl_duty,
  output logic [1:0]         bl_mode,
  output logic [7:0]         bl_duty,
  output logic [1:0]         fr_mode,
  output logic [7:0]         fr_duty,
  output logic [1:0]         br_mode,
  output logic [7:0]         br_duty,
  output logic               drive_locked,
  output logic               frame_ok
);
  import rcdd_pkg::*;

  logic [7:0] l_raw;
  logic [7:0] r_raw;
  logic [7:0] l_duty;
  logic [7:0] r_duty;

  assign mix_ready = !out_valid || out_ready;

  always_comb begin
    l_raw = scale_duty(mix.l_mag);
    r_raw = scale_duty(mix.r_mag);
    l_duty = (l_raw < min_cmd) ? 8'd0 : l_raw;
    r_duty = (r_raw < min_cmd) ? 8'd0 : r_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mix_ready) begin
      out_valid <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_valid && mix_ready) begin
      left_cmd <= mix.l_neg ? -signed'({1'b0, l_duty}) : signed'({1'b0, l_duty});
      right_cmd <= mix.r_neg ? -signed'({1'b0, r_duty}) : signed'({1'b0, r_duty});
      fl_mode <= motor_mode(mix.l_neg, l_duty, invert_mask[0]);
      bl_mode <= motor_mode(mix.l_neg, l_duty, invert_mask[1]);
      fr_mode <= motor_mode(mix.r_neg, r_duty, invert_mask[2]);
      br_mode <= motor_mode(mix.r_neg, r_duty, invert_mask[3]);
      fl_duty <= l_duty;
      bl_duty <= l_duty;
      fr_duty <= r_duty;
      br_duty <= r_duty;
      drive_locked <= mix.locked;
      frame_ok <= mix.ok;
    end
  end

  `RCDD_ASSERT(a_brake_iff_zero, out_valid |-> (fl_mode == MODE_BRAKE) == (fl_duty == 8'd0)
               && (br_mode == MODE_BRAKE) == (br_duty == 8'd0), "brake and duty disagree")
  `RCDD_ASSERT(a_unlocked_stopped, out_valid && !drive_locked |->
               left_cmd == 9'sd0 && right_cmd == 9'sd0, "command while unlocked")

endmodule

// ===== src/rc_differential_drive_mixer_core.sv =====
// Top level of the RC arcade differential drive mixer.
// Each frame is registered in turn in the input, mix and output stages.
// Throughput: one frame per cycle; a stage stalls only while every stage after it
// holds a frame and the result register is full with out_ready low.
// Reset clears the stage valids, the lock counter and lock flag, and loads
// the register defaults (deadband 80, lock 10 frames, min command 10, no invert).
module rc_differential_drive_mixer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rcdd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [8:0]                            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [15:0]                           fwd_pulse_us,
  input  logic [15:0]                           turn_pulse_us,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [8:0]                     left_cmd,
  output logic signed [8:0]                     right_cmd,
  output logic [1:0]                            fl_mode,
  output logic [7:0]                            fl_duty,
  output logic [1:0]                            bl_mode,
  output logic [7:0]                            bl_duty,
  output logic [1:0]                            fr_mode,
  output logic [7:0]                            fr_duty,
  output logic [1:0]                            br_mode,
  output logic [7:0]                            br_duty,
  output logic                                  drive_locked,
  output logic                                  frame_ok
);
  import rcdd_pkg::*;

  cfg_t   cfg;
  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;
  logic   mix_valid;
  logic   mix_ready;
  mix_t   mix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_us <= DEADBAND_RESET;
      cfg.lock_frames <= LOCK_FRAMES_RESET;
      cfg.min_cmd <= MIN_CMD_RESET;
      cfg.invert_mask <= INVERT_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEADBAND_US: cfg.deadband_us <= cfg_data;
        CFG_LOCK_FRAMES: cfg.lock_frames <= cfg_data[7:0];
        CFG_MIN_CMD:     cfg.min_cmd <= cfg_data[7:0];
        CFG_INVERT_MASK: cfg.invert_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  rcdd_lock u_lock (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .fwd_pulse_us  (fwd_pulse_us),
    .turn_pulse_us (turn_pulse_us),
    .lock_frames   (cfg.lock_frames),
    .frame_valid   (frame_valid),
    .frame         (frame),
    .frame_ready   (frame_ready)
  );

  rcdd_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_ready (frame_ready),
    .deadband_us (cfg.deadband_us),
    .mix_valid   (mix_valid),
    .mix         (mix),
    .mix_ready   (mix_ready)
  );

  rcdd_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .mix_valid    (mix_valid),
    .mix          (mix),
    .mix_ready    (mix_ready),
    .min_cmd      (cfg.min_cmd),
    .invert_mask  (cfg.invert_mask),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_cmd     (left_cmd),
    .right_cmd    (right_cmd),
    .fl_mode      (fl_mode),
    .fl_duty      (fl_duty),
    .bl_mode      (bl_mode),
    .bl_duty      (bl_duty),
    .fr_mode      (fr_mode),
    .fr_duty      (fr_duty),
    .br_mode      (br_mode),
    .br_duty      (br_duty),
    .drive_locked (drive_locked),
    .frame_ok     (frame_ok)
  );

endmodule

// ===== sim/tb.sv =====
// RC differential drive mixer testbench: directed and random frames checked against expected results.
`timescale 1ns / 1ps

module tb;
  import rcdd_pkg::*;

  localparam int PULSE_CENTER = 1500;
  localparam int FULL_SPAN = 500;
  localparam int DUTY_MAX = 255;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'hFF;

  typedef struct packed {
    logic signed [8:0] left_cmd;
    logic signed [8:0] right_cmd;
    logic [1:0]        fl_mode;
    logic [7:0]        fl_duty;
    logic [1:0]        bl_mode;
    logic [7:0]        bl_duty;
    logic [1:0]        fr_mode;
    logic [7:0]        fr_duty;
    logic [1:0]        br_mode;
    logic [7:0]        br_duty;
    logic              drive_locked;
    logic              frame_ok;
  } mix_result_t;

  typedef struct packed {
    logic [15:0]       fwd;
    logic [15:0]       turn;
    logic              known;
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic              locked;
    logic              ok;
  } frame_row_t;

  typedef struct packed {
    logic [8:0] deadband;
    logic [8:0] lock_count;
    logic [8:0] min_duty;
    logic [8:0] invert;
    logic [6:0] send_idle;
    logic [6:0] recv_stall;
    logic [6:0] bad_pct;
    logic [9:0] frames;
  } drive_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] fwd_pulse_us = '0;
  logic [15:0] turn_pulse_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [8:0] left_cmd;
  logic signed [8:0] right_cmd;
  logic [1:0] fl_mode;
  logic [7:0] fl_duty;
  logic [1:0] bl_mode;
  logic [7:0] bl_duty;
  logic [1:0] fr_mode;
  logic [7:0] fr_duty;
  logic [1:0] br_mode;
  logic [7:0] br_duty;
  logic drive_locked;
  logic frame_ok;

  int deadband_q = 80;
  int lock_after = 10;
  int min_duty_q = 10;
  logic [3:0] invert_bits = 4'd0;
  int valid_run = 0;
  bit drive_held = 1'b0;

  mix_result_t pending_mix[$];
  int mismatches = 0;
  int sender_idle = 0;
  int stall_pct = 0;

  frame_row_t directed_rows [NUM_DIRECTED];
  drive_phase_t phases [NUM_PHASES];

  rc_differential_drive_mixer_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .fwd_pulse_us(fwd_pulse_us), .turn_pulse_us(turn_pulse_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_cmd(left_cmd), .right_cmd(right_cmd),
    .fl_mode(fl_mode), .fl_duty(fl_duty), .bl_mode(bl_mode), .bl_duty(bl_duty),
    .fr_mode(fr_mode), .fr_duty(fr_duty), .br_mode(br_mode), .br_duty(br_duty),
    .drive_locked(drive_locked), .frame_ok(frame_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int limit_span(input int v);
    if (v > FULL_SPAN) return FULL_SPAN;
    if (v < -FULL_SPAN) return -FULL_SPAN;
    return v;
  endfunction

  function automatic int offset_of(input logic [15:0] us);
    int d;
    int mag;
    d = int'(us) - PULSE_CENTER;
    mag = (d < 0) ? -d : d;
    if (mag <= deadband_q) return 0;
    return limit_span(d);
  endfunction

  function automatic int side_duty(input int s);
    int mag;
    int c;
    mag = (s < 0) ? -s : s;
    c = (mag * DUTY_MAX) / FULL_SPAN;
    if (c < min_duty_q) c = 0;
    return (s < 0) ? -c : c;
  endfunction

  function automatic void drive_motor(input int cmd, input logic inv,
                                      output logic [1:0] mode, output logic [7:0] duty);
    if (cmd == 0) begin
      mode = MODE_BRAKE;
      duty = 8'd0;
    end else begin
      mode = ((cmd > 0) != inv) ? MODE_FWD : MODE_REV;
      duty = 8'((cmd < 0) ? -cmd : cmd);
    end
  endfunction

  function automatic mix_result_t mix_from_cmds(input int l, input int r, input bit locked,
                                                input bit ok);
    mix_result_t m;
    m.left_cmd = 9'(l);
    m.right_cmd = 9'(r);
    drive_motor(l, invert_bits[0], m.fl_mode, m.fl_duty);
    drive_motor(l, invert_bits[1], m.bl_mode, m.bl_duty);
    drive_motor(r, invert_bits[2], m.fr_mode, m.fr_duty);
    drive_motor(r, invert_bits[3], m.br_mode, m.br_duty);
    m.drive_locked = locked;
    m.frame_ok = ok;
    return m;
  endfunction

  function automatic mix_result_t mix_frame(input logic [15:0] fwd, input logic [15:0] turn);
    bit ok;
    bit drive;
    int f_ofs;
    int t_ofs;
    int l;
    int r;
    ok = fwd >= PULSE_MIN && fwd <= PULSE_MAX && turn >= PULSE_MIN && turn <= PULSE_MAX;
    drive = 1'b0;
    l = 0;
    r = 0;
    if (!ok) begin
      valid_run = 0;
      drive_held = 1'b0;
    end else if (!drive_held && valid_run < lock_after) begin
      valid_run = (valid_run + 1) & 8'hFF;
    end else begin
      drive_held = 1'b1;
      drive = 1'b1;
    end
    if (drive) begin
      f_ofs = offset_of(fwd);
      t_ofs = offset_of(turn);
      l = side_duty(limit_span(f_ofs + t_ofs));
      r = side_duty(limit_span(f_ofs - t_ofs));
    end
    return mix_from_cmds(l, r, drive_held, ok);
  endfunction

  function automatic logic [15:0] pulse_value();
    case ($urandom_range(7))
      0: return PULSE_MIN;
      1: return PULSE_MAX;
      2: return 16'(PULSE_CENTER - 60 + $urandom_range(120));
      default: return 16'($urandom_range(int'(PULSE_MAX), int'(PULSE_MIN)));
    endcase
  endfunction

  function automatic logic [15:0] bad_pulse();
    return $urandom_range(1) ? PULSE_MIN - 16'd1 : PULSE_MAX + 16'd1;
  endfunction

  function automatic void pick_frame(input int bad_pct, output logic [15:0] fwd,
                                     output logic [15:0] turn);
    fwd = pulse_value();
    turn = pulse_value();
    if ($urandom_range(99) < bad_pct) begin
      case ($urandom_range(3))
        0: begin
          fwd = 16'($urandom);
          turn = 16'($urandom);
        end
        1: begin
          fwd = 16'd0;
          turn = 16'd0;
        end
        2: turn = $urandom_range(1) ? bad_pulse() : 16'($urandom);
        default: fwd = bad_pulse();
      endcase
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_result();
    mix_result_t want;
    if (pending_mix.size() == 0) begin
      flag_mismatch("result with nothing pending, left_cmd", left_cmd, 0);
    end else begin
      want = pending_mix.pop_front();
      if (left_cmd !== want.left_cmd) flag_mismatch("left_cmd", left_cmd, want.left_cmd);
      if (right_cmd !== want.right_cmd) flag_mismatch("right_cmd", right_cmd, want.right_cmd);
      if (fl_mode !== want.fl_mode) flag_mismatch("fl_mode", fl_mode, want.fl_mode);
      if (fl_duty !== want.fl_duty) flag_mismatch("fl_duty", fl_duty, want.fl_duty);
      if (bl_mode !== want.bl_mode) flag_mismatch("bl_mode", bl_mode, want.bl_mode);
      if (bl_duty !== want.bl_duty) flag_mismatch("bl_duty", bl_duty, want.bl_duty);
      if (fr_mode !== want.fr_mode) flag_mismatch("fr_mode", fr_mode, want.fr_mode);
      if (fr_duty !== want.fr_duty) flag_mismatch("fr_duty", fr_duty, want.fr_duty);
      if (br_mode !== want.br_mode) flag_mismatch("br_mode", br_mode, want.br_mode);
      if (br_duty !== want.br_duty) flag_mismatch("br_duty", br_duty, want.br_duty);
      if (drive_locked !== want.drive_locked)
        flag_mismatch("drive_locked", drive_locked, want.drive_locked);
      if (frame_ok !== want.frame_ok) flag_mismatch("frame_ok", frame_ok, want.frame_ok);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_frame(input logic [15:0] fwd, input logic [15:0] turn, input bit known,
                            input mix_result_t typed);
    mix_result_t want;
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    fwd_pulse_us <= fwd;
    turn_pulse_us <= turn;
    do @(posedge clk); while (!in_ready);
    want = mix_frame(fwd, turn);
    if (known) want = typed;
    pending_mix.push_back(want);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_DEADBAND_US: deadband_q = int'(data);
      CFG_LOCK_FRAMES: lock_after = int'(data[7:0]);
      CFG_MIN_CMD:     min_duty_q = int'(data[7:0]);
      CFG_INVERT_MASK: invert_bits = data[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_mix.size() != 0) @(posedge clk);
  endtask

  initial begin
    frame_row_t row;
    drive_phase_t ph;
    logic [15:0] fwd;
    logic [15:0] turn;
    mix_result_t none;

    directed_rows[0] = '{16'd0, 16'd0, 1'b1, 9'sd0, 9'sd0, 1'b0, 1'b0};
    directed_rows[1] = '{16'hFFFF, 16'hFFFF, 1'b1, 9'sd0, 9'sd0, 1'b0, 1'b0};
    directed_rows[2] = '{16'd899, 16'd1500, 1'b1, 9'sd0, 9'sd0, 1'b0, 1'b0};
    directed_rows[3] = '{16'd1500, 16'd2101, 1'b1, 9'sd0, 9'sd0, 1'b0, 1'b0};
    for (int i = 4; i < 14; i++)
      directed_rows[i] = '{16'd1500, 16'd1500, 1'b1, 9'sd0, 9'sd0, 1'b0, 1'b1};
    directed_rows[14] = '{16'd1500, 16'd1500, 1'b1, 9'sd0, 9'sd0, 1'b1, 1'b1};
    directed_rows[15] = '{16'd2100, 16'd1500, 1'b1, 9'sd255, 9'sd255, 1'b1, 1'b1};
    directed_rows[16] = '{16'd900, 16'd1500, 1'b1, -9'sd255, -9'sd255, 1'b1, 1'b1};
    directed_rows[17] = '{16'd2100, 16'd2100, 1'b1, 9'sd255, 9'sd0, 1'b1, 1'b1};
    directed_rows[18] = '{16'd1500, 16'd900, 1'b1, -9'sd255, 9'sd255, 1'b1, 1'b1};
    directed_rows[19] = '{16'd1580, 16'd1500, 1'b1, 9'sd0, 9'sd0, 1'b1, 1'b1};
    directed_rows[20] = '{16'd1581, 16'd1500, 1'b0, 9'sd0, 9'sd0, 1'b0, 1'b0};
    directed_rows[21] = '{16'd1700, 16'd1400, 1'b0, 9'sd0, 9'sd0, 1'b0, 1'b0};
    directed_rows[22] = '{16'd900, 16'd2100, 1'b1, 9'sd0, -9'sd255, 1'b1, 1'b1};
    directed_rows[23] = '{16'd2100, 16'd0, 1'b1, 9'sd0, 9'sd0, 1'b0, 1'b0};
    directed_rows[24] = '{16'd2100, 16'd2100, 1'b1, 9'sd0, 9'sd0, 1'b0, 1'b1};

    phases[0] = '{9'd0, 9'd0, 9'd0, 9'd0, 7'd0, 7'd0, 7'd10, 10'd60};
    phases[1] = '{9'd500, 9'd3, 9'h1FF, 9'h1FF, 7'd79, 7'd0, 7'd10, 10'd60};
    phases[2] = '{9'h1FF, 9'd255, 9'd1, 9'd5, 7'd0, 7'd79, 7'd0, 10'd280};
    phases[3] = '{9'd40, 9'd1, 9'd10, 9'd10, 7'd17, 7'd17, 7'd15, 10'd60};
    phases[4] = '{9'd80, 9'd10, 9'd128, 9'd3, 7'd0, 7'd0, 7'd10, 10'd60};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      none = mix_from_cmds(int'(row.left), int'(row.right), row.locked, row.ok);
      send_frame(row.fwd, row.turn, row.known, none);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = phases[p];
      in_valid <= 1'b0;
      wait_drained();
      write_reg(CFG_DEADBAND_US, ph.deadband);
      write_reg(CFG_LOCK_FRAMES, ph.lock_count);
      write_reg(CFG_MIN_CMD, ph.min_duty);
      write_reg(CFG_INVERT_MASK, ph.invert);
      write_reg(CFG_UNUSED_INDEX, 9'h155);
      cfg_valid <= 1'b0;
      sender_idle = int'(ph.send_idle);
      stall_pct = int'(ph.recv_stall);
      for (int n = 0; n < int'(ph.frames); n++) begin
        pick_frame(int'(ph.bad_pct), fwd, turn);
        send_frame(fwd, turn, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
